// ===== hw/rtl/cosine_similarity_best_match_top_assert.svh =====
// assertion macros for the cosine similarity best match block
`ifndef COSINE_SIMILARITY_BEST_MATCH_TOP_ASSERT_SVH
`define COSINE_SIMILARITY_BEST_MATCH_TOP_ASSERT_SVH
`ifndef SYNTH
`define CSBM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define CSBM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define CSBM_ASSERT_IMP(label, ante, cons)
`define CSBM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/cs_pkg.sv =====
// shared types and constants for the cosine similarity best match block
package cs_pkg;
	localparam int ValW = 16;
	localparam int AccW = 40;
	localparam int IdxW = 10;
	localparam int MaxEntries = 1024;
	localparam int IdxLastInt = (MaxEntries - 1 < 1023) ? MaxEntries - 1 : 1023;
	localparam logic [IdxW-1:0] IdxLast = IdxLastInt[IdxW-1:0];

	typedef struct packed {
		logic signed [AccW-1:0] dot;
		logic [AccW-1:0] nq;
		logic [AccW-1:0] ne;
		logic [IdxW-1:0] idx;
		logic dend;
	} cs_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cs_qstat_t;
endpackage

// ===== hw/rtl/cs_stream_if.sv =====
// stream interfaces for element pairs and score results
interface cs_in_if;
	import cs_pkg::*;
	logic valid;
	logic ready;
	logic signed [ValW-1:0] query_value;
	logic signed [ValW-1:0] entry_value;
	logic vector_end;
	logic database_end;
	modport source(output valid, query_value, entry_value, vector_end, database_end,
		input ready);
	modport sink(input valid, query_value, entry_value, vector_end, database_end,
		output ready);
endinterface

interface cs_out_if;
	import cs_pkg::*;
	logic valid;
	logic ready;
	logic [IdxW-1:0] entry_index;
	logic signed [ValW-1:0] similarity;
	logic [IdxW-1:0] best_index;
	logic signed [ValW-1:0] best_sim;
	logic final_res;
	modport source(output valid, entry_index, similarity, best_index, best_sim, final_res,
		input ready);
	modport sink(input valid, entry_index, similarity, best_index, best_sim, final_res,
		output ready);
endinterface

// ===== hw/rtl/cosine_similarity_best_match_top.sv =====
// top level of the cosine similarity best match block
// elements: one beat per cycle, entering a two stage multiply and accumulate front end
// (the input stalls while a vector end waits on a full job queue)
// per vector the back end multiplies the norms, takes the square root, divides and emits
// a two entry job queue lets the front end run on while the back end scores
// arst_n clears accumulators, entry count, best match and all valid flags at once
`include "cosine_similarity_best_match_top_assert.svh"
module cosine_similarity_best_match_top (
	input logic clk,
	input logic arst_n,
	cs_in_if.sink item,
	cs_out_if.source result
);
	import cs_pkg::*;

	cs_job_t job_in, job_out;
	cs_qstat_t qstat;
	logic push, pop;

	cs_front u_front (
		.clk(clk), .arst_n(arst_n), .item(item), .qstat(qstat), .push(push), .job(job_in)
	);

	cs_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(job_in), .pop(pop),
		.dout(job_out), .qstat(qstat)
	);

	cs_back u_back (
		.clk(clk), .arst_n(arst_n), .job(job_out), .qstat(qstat), .pop(pop), .result(result)
	);

	`CSBM_ASSERT_IMP(a_no_push_full, push, !qstat.full)
	`CSBM_ASSERT_IMP(a_no_pop_empty, pop, !qstat.empty)
	`CSBM_ASSERT_IMP(a_best_dominates, result.valid, result.similarity <= result.best_sim)
endmodule

// ===== hw/rtl/cs_front.sv =====
// front end: element products, saturating accumulation, job issue per vector
module cs_front (
	input logic clk,
	input logic arst_n,
	cs_in_if.sink item,
	input cs_pkg::cs_qstat_t qstat,
	output logic push,
	output cs_pkg::cs_job_t job
);
	import cs_pkg::*;

	logic v_s1, vend_s1, dend_s1;
	logic signed [31:0] dp_s1;
	logic [30:0] qq_s1, ee_s1;
	logic signed [AccW-1:0] dot_q;
	logic [AccW-1:0] nq_q, ne_q;
	logic [IdxW-1:0] cnt_q;
	logic stall, accept;
	logic signed [AccW:0] dsum;
	logic [AccW:0] qsum, esum;
	logic signed [AccW-1:0] dot_n;
	logic [AccW-1:0] nq_n, ne_n;
	logic signed [31:0] qq_full, ee_full;

	assign stall = v_s1 && vend_s1 && qstat.full;
	assign item.ready = !stall;
	assign accept = item.valid && !stall;
	assign qq_full = item.query_value * item.query_value;
	assign ee_full = item.entry_value * item.entry_value;

	always_comb begin
		dsum = {dot_q[AccW-1], dot_q} + (AccW+1)'(dp_s1);
		qsum = {1'b0, nq_q} + (AccW+1)'(qq_s1);
		esum = {1'b0, ne_q} + (AccW+1)'(ee_s1);
		if (dsum[AccW] != dsum[AccW-1]) begin
			dot_n = dsum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
		end else begin
			dot_n = dsum[AccW-1:0];
		end
		nq_n = qsum[AccW] ? {AccW{1'b1}} : qsum[AccW-1:0];
		ne_n = esum[AccW] ? {AccW{1'b1}} : esum[AccW-1:0];
	end

	assign push = v_s1 && vend_s1 && !qstat.full;
	assign job = '{dot: dot_n, nq: nq_n, ne: ne_n, idx: cnt_q, dend: dend_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			dot_q <= '0;
			nq_q <= '0;
			ne_q <= '0;
			cnt_q <= '0;
		end else if (!stall) begin
			v_s1 <= accept;
			if (v_s1) begin
				if (vend_s1) begin
					dot_q <= '0;
					nq_q <= '0;
					ne_q <= '0;
					cnt_q <= (dend_s1 || cnt_q == IdxLast) ? '0 : cnt_q + 1'b1;
				end else begin
					dot_q <= dot_n;
					nq_q <= nq_n;
					ne_q <= ne_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dp_s1 <= item.query_value * item.entry_value;
			qq_s1 <= qq_full[30:0];
			ee_s1 <= ee_full[30:0];
			vend_s1 <= item.vector_end;
			dend_s1 <= item.vector_end && item.database_end;
		end
	end
endmodule

// ===== hw/rtl/cs_fifo.sv =====
// two entry job queue between front and back end
module cs_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cs_pkg::cs_job_t din,
	input logic pop,
	output cs_pkg::cs_job_t dout,
	output cs_pkg::cs_qstat_t qstat
);
	import cs_pkg::*;

	cs_job_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign dout = slot_q[rp_q];
	assign qstat = '{full: cnt_q == 2'd2, empty: cnt_q == 2'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= din;
	end
endmodule

// ===== hw/rtl/cs_back.sv =====
// back end: norm product, square root, divide, best match and result register
module cs_back (
	input logic clk,
	input logic arst_n,
	input cs_pkg::cs_job_t job,
	input cs_pkg::cs_qstat_t qstat,
	output logic pop,
	cs_out_if.source result
);
	import cs_pkg::*;

	typedef enum logic [2:0] {IDLE, MUL, SQRT, DIVI, DIV, EMIT} state_t;
	state_t state_q;

	logic [AccW-1:0] nq_q, ne_q, mag_q, root_q;
	logic neg_q, zero_q, dend_q, ovf_q;
	logic [IdxW-1:0] idx_q;
	logic [79:0] prod_q;
	logic [41:0] rem_q;
	logic [55:0] num_q, dv_q;
	logic [15:0] quo_q;
	logic [5:0] cnt_q;
	logic [1:0] step_q;
	logic seen_q;
	logic [IdxW-1:0] best_idx_q;
	logic signed [ValW-1:0] best_sc_q;
	logic valid_q;

	logic [19:0] ma, mb;
	logic [39:0] pp;
	logic [79:0] pp_sh;
	logic [43:0] rem_sh, trial;
	logic div_ge;
	logic signed [ValW-1:0] sim;
	logic better, out_free, emit;

	assign pop = state_q == IDLE && !qstat.empty;
	assign out_free = !valid_q || result.ready;
	assign emit = state_q == EMIT && out_free;

	always_comb begin
		ma = step_q[1] ? nq_q[39:20] : nq_q[19:0];
		mb = step_q[0] ? ne_q[39:20] : ne_q[19:0];
		pp = ma * mb;
		pp_sh = 80'(pp) << (6'd20 * ({5'd0, step_q[1]} + {5'd0, step_q[0]}));
		rem_sh = {rem_q, prod_q[79:78]};
		trial = {2'b00, root_q, 2'b01};
		div_ge = num_q >= dv_q;
		if (zero_q) begin
			sim = '0;
		end else if (neg_q) begin
			sim = (ovf_q || quo_q > 16'd32768) ? 16'sh8000 : $signed(~quo_q + 16'd1);
		end else begin
			sim = (ovf_q || quo_q > 16'd32767) ? 16'sh7fff : $signed(quo_q);
		end
		better = !seen_q || sim > best_sc_q;
	end

	assign result.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			valid_q <= 1'b0;
			seen_q <= 1'b0;
			best_idx_q <= '0;
			best_sc_q <= '0;
			cnt_q <= '0;
			step_q <= '0;
		end else begin
			valid_q <= emit || (valid_q && !result.ready);
			unique case (state_q)
				IDLE: begin
					if (!qstat.empty) begin
						nq_q <= job.nq;
						ne_q <= job.ne;
						neg_q <= job.dot < 0;
						mag_q <= (job.dot < 0) ? 40'(-job.dot) : job.dot;
						zero_q <= job.nq == '0 || job.ne == '0;
						idx_q <= job.idx;
						dend_q <= job.dend;
						prod_q <= '0;
						step_q <= '0;
						state_q <= MUL;
					end
				end
				MUL: begin
					prod_q <= prod_q + pp_sh;
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						rem_q <= '0;
						root_q <= '0;
						cnt_q <= 6'd39;
						state_q <= SQRT;
					end
				end
				SQRT: begin
					prod_q <= prod_q << 2;
					if (rem_sh >= trial) begin
						rem_q <= 42'(rem_sh - trial);
						root_q <= {root_q[38:0], 1'b1};
					end else begin
						rem_q <= rem_sh[41:0];
						root_q <= {root_q[38:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= DIVI;
				end
				DIVI: begin
					dv_q <= 56'(root_q) << 15;
					num_q <= 56'(mag_q) << 15;
					ovf_q <= {1'b0, mag_q} >= {root_q, 1'b0};
					quo_q <= '0;
					cnt_q <= 6'd15;
					state_q <= DIV;
				end
				DIV: begin
					if (div_ge) num_q <= num_q - dv_q;
					quo_q <= {quo_q[14:0], div_ge};
					dv_q <= dv_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= EMIT;
				end
				EMIT: begin
					if (out_free) begin
						result.entry_index <= idx_q;
						result.similarity <= sim;
						result.best_index <= better ? idx_q : best_idx_q;
						result.best_sim <= better ? sim : best_sc_q;
						result.final_res <= dend_q;
						if (dend_q) begin
							seen_q <= 1'b0;
							best_idx_q <= '0;
							best_sc_q <= '0;
						end else if (better) begin
							seen_q <= 1'b1;
							best_idx_q <= idx_q;
							best_sc_q <= sim;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
